/* design/jpeg_entropy_segment_check_unit_macros.svh */
// Assertion macros for the entropy segment check unit.
`ifndef JPEG_ENTROPY_SEGMENT_CHECK_UNIT_MACROS_SVH
`define JPEG_ENTROPY_SEGMENT_CHECK_UNIT_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define JESC_ASSERT_NOW(label, ante, cons, msg) \
label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define JESC_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
else $error(msg);

`endif

/* design/jesc_pkg.sv */
// Shared types and constants for the entropy segment check unit.
package jesc_pkg;

    localparam int LENGTH_BITS   = 24;
    localparam int RESTART_BITS  = 20;
    localparam int INTERVAL_BITS = 16;
    localparam int MCU_BITS      = 21;
    localparam int PRODUCT_BITS  = RESTART_BITS + INTERVAL_BITS;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 21;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MCUS_PER_RESTART = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TOTAL_MCUS       = 1'd1;

    localparam logic [7:0] FILL_BYTE  = 8'hff;
    localparam logic [7:0] STUFF_BYTE = 8'h00;
    localparam logic [7:0] RST_FIRST  = 8'hd0;
    localparam logic [7:0] RST_LAST   = 8'hd7;
    localparam logic [7:0] EOI_CODE   = 8'hd9;

    localparam logic [1:0] FILL_RUN_MAX = 2'd3;
    localparam logic [LENGTH_BITS-1:0] MIN_LENGTH = LENGTH_BITS'(2);

    typedef enum logic [1:0] {
        ST_VALID       = 2'd0,
        ST_INVALID     = 2'd1,
        ST_UNSUPPORTED = 2'd2
    } t_status;

    // Scan stage -> verdict stage, for a final byte.
    typedef struct packed {
        logic                      err_known;   // status settled without restart/length check
        t_status                   err_code;
        logic                      tally_zero;  // restart count before the final byte is zero
        logic [PRODUCT_BITS-1:0]   product;     // restart count times interval
        logic [RESTART_BITS-1:0]   restarts;
        logic [LENGTH_BITS-1:0]    length;
    } t_scan_result;

endpackage

/* design/jesc_cfg_regs.sv */
// Configuration registers: restart interval and MCU count.
module jesc_cfg_regs
    import jesc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    output logic [INTERVAL_BITS-1:0]  o_mcus_per_restart,
    output logic [MCU_BITS-1:0]       o_last_mcu
);

    logic [INTERVAL_BITS-1:0] r_mcus_per_restart;
    logic [MCU_BITS-1:0]      r_total_mcus;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcus_per_restart <= '0;
            r_total_mcus       <= MCU_BITS'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MCUS_PER_RESTART: r_mcus_per_restart <= i_cfg_data[INTERVAL_BITS-1:0];
                CFG_TOTAL_MCUS:       r_total_mcus       <= i_cfg_data[MCU_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_mcus_per_restart = r_mcus_per_restart;
    // zero MCUs counts as one
    assign o_last_mcu = (r_total_mcus == '0) ? '0 : r_total_mcus - MCU_BITS'(1);

endmodule

/* design/jesc_scan.sv */
// Input register and per-byte scan of fill runs, markers and tallies.
module jesc_scan
    import jesc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [7:0]               i_data_byte,
    input  logic                     i_final_byte,
    input  logic [INTERVAL_BITS-1:0] i_mcus_per_restart,
    input  logic                     i_p_free,
    output logic                     o_load,
    output t_scan_result             o_result
);

    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_final;

    logic                    r_in_fill_run, n_in_fill_run;
    logic [1:0]              r_fill_run_length, n_fill_run_length;
    logic [RESTART_BITS-1:0] r_restart_tally, n_restart_tally;
    logic [LENGTH_BITS-1:0]  r_byte_tally, n_byte_tally;
    t_status                 r_sticky_error, n_sticky_error;
    logic                    r_end_marker_seen, n_end_marker_seen;

    logic fire;
    logic accept;
    logic is_rst;

    assign fire       = r_s1_valid && (!r_s1_final || i_p_free);
    assign o_in_stall = r_s1_valid && !fire;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_load     = fire && r_s1_final;
    assign is_rst     = (r_s1_byte >= RST_FIRST) && (r_s1_byte <= RST_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_byte  <= i_data_byte;
            r_s1_final <= i_final_byte;
        end
    end

    always_comb begin
        n_in_fill_run     = r_in_fill_run;
        n_fill_run_length = r_fill_run_length;
        n_restart_tally   = r_restart_tally;
        n_sticky_error    = r_sticky_error;
        n_end_marker_seen = r_end_marker_seen;
        n_byte_tally      = (r_byte_tally == '1) ? r_byte_tally
                                                 : r_byte_tally + LENGTH_BITS'(1);

        if (r_sticky_error == ST_VALID) begin
            if (r_in_fill_run) begin
                if (r_s1_byte == FILL_BYTE) begin
                    if (r_fill_run_length != FILL_RUN_MAX) begin
                        n_fill_run_length = r_fill_run_length + 2'd1;
                    end
                end else begin
                    n_in_fill_run     = 1'b0;
                    n_fill_run_length = 2'd0;
                    priority if (r_s1_byte == STUFF_BYTE) begin
                        if (r_fill_run_length != 2'd1) begin
                            n_sticky_error = ST_INVALID;
                        end
                    end else if (is_rst) begin
                        // expected RST follows the low three bits of the tally
                        if (i_mcus_per_restart == '0 ||
                            r_s1_byte[2:0] != r_restart_tally[2:0]) begin
                            n_sticky_error = ST_INVALID;
                        end else if (r_restart_tally != '1) begin
                            n_restart_tally = r_restart_tally + RESTART_BITS'(1);
                        end
                    end else if (r_s1_byte == EOI_CODE && r_s1_final) begin
                        n_end_marker_seen = 1'b1;
                    end else begin
                        n_sticky_error = ST_UNSUPPORTED;
                    end
                end
            end else if (r_s1_byte == FILL_BYTE) begin
                n_in_fill_run     = 1'b1;
                n_fill_run_length = 2'd1;
            end
        end
    end

    // A good verdict needs EOI on the final byte, so the tally does not move on
    // that byte and the product can use the registered tally.
    always_comb begin
        o_result.tally_zero = (r_restart_tally == '0);
        o_result.product    = PRODUCT_BITS'(r_restart_tally) * PRODUCT_BITS'(i_mcus_per_restart);
        o_result.restarts   = n_restart_tally;
        o_result.length     = n_byte_tally;
        o_result.err_known  = 1'b1;
        priority if (n_sticky_error != ST_VALID) begin
            o_result.err_code = n_sticky_error;
        end else if (n_in_fill_run || !n_end_marker_seen) begin
            o_result.err_code = ST_INVALID;
        end else begin
            o_result.err_code  = ST_VALID;
            o_result.err_known = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_load) begin
            r_in_fill_run     <= 1'b0;
            r_fill_run_length <= 2'd0;
            r_restart_tally   <= '0;
            r_byte_tally      <= '0;
            r_sticky_error    <= ST_VALID;
            r_end_marker_seen <= 1'b0;
        end else if (fire) begin
            r_in_fill_run     <= n_in_fill_run;
            r_fill_run_length <= n_fill_run_length;
            r_restart_tally   <= n_restart_tally;
            r_byte_tally      <= n_byte_tally;
            r_sticky_error    <= n_sticky_error;
            r_end_marker_seen <= n_end_marker_seen;
        end
    end

endmodule

/* design/jesc_verdict.sv */
// Pending-result register, restart count check and output register.
module jesc_verdict
    import jesc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  t_scan_result             i_result,
    output logic                     o_p_free,
    input  logic [INTERVAL_BITS-1:0] i_mcus_per_restart,
    input  logic [MCU_BITS-1:0]      i_last_mcu,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_status,
    output logic [LENGTH_BITS-1:0]   o_segment_length,
    output logic [RESTART_BITS-1:0]  o_restarts_seen
);

    logic         r_p_valid;
    t_scan_result r_p;

    logic                    r_out_valid;
    t_status                 r_status;
    logic [LENGTH_BITS-1:0]  r_segment_length;
    logic [RESTART_BITS-1:0] r_restarts_seen;

    logic                    advance_o;
    logic                    move_p;
    logic [PRODUCT_BITS-1:0] last_ext;
    logic [PRODUCT_BITS-1:0] gap;
    logic                    restarts_ok;
    t_status                 status;

    assign advance_o = !r_out_valid || !i_out_stall;
    assign move_p    = r_p_valid && advance_o;
    assign o_p_free  = !r_p_valid || move_p;

    // tally*I <= last < (tally+1)*I
    assign last_ext = PRODUCT_BITS'(i_last_mcu);
    assign gap      = last_ext - r_p.product;

    always_comb begin
        if (i_mcus_per_restart == '0) begin
            restarts_ok = r_p.tally_zero;
        end else begin
            restarts_ok = (r_p.product <= last_ext) &&
                          (gap < PRODUCT_BITS'(i_mcus_per_restart));
        end
        priority if (r_p.err_known) begin
            status = r_p.err_code;
        end else if (!restarts_ok || r_p.length <= MIN_LENGTH) begin
            status = ST_INVALID;
        end else begin
            status = ST_VALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (i_load) begin
            r_p_valid <= 1'b1;
        end else if (move_p) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_p <= i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance_o) begin
            r_out_valid <= move_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move_p) begin
            r_status         <= status;
            r_segment_length <= r_p.length;
            r_restarts_seen  <= r_p.restarts;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_segment_length = r_segment_length;
    assign o_restarts_seen  = r_restarts_seen;

endmodule

/* design/jpeg_entropy_segment_check_unit.sv */
// Top level of the JPEG entropy-coded segment check unit.
//
//  channel   valid          flow control   payload
//  input     i_in_valid     o_in_stall     i_data_byte, i_final_byte
//  output    o_out_valid    i_out_stall    o_status, o_segment_length, o_restarts_seen
//  config    i_cfg_valid    o_cfg_ready    i_cfg_index, i_cfg_data
//
// One byte request per cycle while o_in_stall is low. Once a final byte is taken
// into the input register, the scan of the input register loads the pending register
// with the restart product, then the compare loads the output register. Bytes that
// end no segment keep flowing while a result waits under i_out_stall. Reset
// (synchronous, i_rst_n low) clears all tallies; config is ready every cycle.
module jpeg_entropy_segment_check_unit
    import jesc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [7:0]                i_data_byte,
    input  logic                      i_final_byte,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [1:0]                o_status,
    output logic [LENGTH_BITS-1:0]    o_segment_length,
    output logic [RESTART_BITS-1:0]   o_restarts_seen,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    logic [INTERVAL_BITS-1:0] mcus_per_restart;
    logic [MCU_BITS-1:0]      last_mcu;
    logic                     p_free;
    logic                     load;
    t_scan_result             scan_result;

    jesc_cfg_regs u_cfg_regs (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_mcus_per_restart (mcus_per_restart),
        .o_last_mcu         (last_mcu)
    );

    jesc_scan u_scan (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_data_byte        (i_data_byte),
        .i_final_byte       (i_final_byte),
        .i_mcus_per_restart (mcus_per_restart),
        .i_p_free           (p_free),
        .o_load             (load),
        .o_result           (scan_result)
    );

    jesc_verdict u_verdict (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_load             (load),
        .i_result           (scan_result),
        .o_p_free           (p_free),
        .i_mcus_per_restart (mcus_per_restart),
        .i_last_mcu         (last_mcu),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_segment_length   (o_segment_length),
        .o_restarts_seen    (o_restarts_seen)
    );

endmodule

/* design/jesc_checker.sv */
// Port-level assertions for the segment check unit, bound to the top level.
`include "jpeg_entropy_segment_check_unit_macros.svh"

module jesc_checker
    import jesc_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [1:0]                o_status,
    input logic [LENGTH_BITS-1:0]    o_segment_length,
    input logic [RESTART_BITS-1:0]   o_restarts_seen
);

    logic [LENGTH_BITS-1:0] restart_bytes;

    // every counted restart marker costs a fill byte and a code byte
    assign restart_bytes = LENGTH_BITS'(o_restarts_seen) << 1;

    `JESC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_status) && $stable(o_segment_length) && $stable(o_restarts_seen), "result changed under stall")

    `JESC_ASSERT_NOW(a_status_code, o_out_valid, o_status != 2'd3, "undefined status code")

    `JESC_ASSERT_NOW(a_good_len, o_out_valid && o_status == ST_VALID, o_segment_length > MIN_LENGTH, "good segment too short")

    `JESC_ASSERT_NOW(a_rst_bytes, o_out_valid, restart_bytes <= o_segment_length, "more restarts than bytes allow")

endmodule

bind jpeg_entropy_segment_check_unit jesc_checker u_jesc_checker (.*);

/* dv/jpeg_entropy_segment_check_unit_test.sv */
// Self-checking testbench for the JPEG entropy-coded segment check unit.
`timescale 1ns / 100ps

module jpeg_entropy_segment_check_unit_test;
    import jesc_pkg::*;

    localparam int TOTAL_BYTES  = 470;
    localparam int DRAIN_CYCLES = 6;

    typedef struct packed {
        t_status                 status;
        logic [LENGTH_BITS-1:0]  seg_len;
        logic [RESTART_BITS-1:0] restarts;
    } t_verdict;

    typedef enum logic {ROW_BYTE, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                 kind;
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [CFG_DATA_BITS-1:0]  arg;    // byte value, or register data
        logic                      fin;
        logic                      typed;  // verdict written out below
        t_status                   st;
        logic [LENGTH_BITS-1:0]    len;
        logic [RESTART_BITS-1:0]   rst;
    } t_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [7:0]                i_data_byte = 8'h00;
    logic                      i_final_byte = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [1:0]                o_status;
    logic [LENGTH_BITS-1:0]    o_segment_length;
    logic [RESTART_BITS-1:0]   o_restarts_seen;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data = '0;

    jpeg_entropy_segment_check_unit DUT (.*);

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // segment tracker state, mirrors the unit
    logic [INTERVAL_BITS-1:0] model_interval = '0;
    logic [MCU_BITS-1:0]      model_mcus = MCU_BITS'(1);
    t_status                  err_flag = ST_VALID;
    logic                     in_run = 1'b0;
    logic [1:0]               run_len = 2'd0;
    logic [RESTART_BITS-1:0]  rst_tally = '0;
    logic [LENGTH_BITS-1:0]   byte_tally = '0;
    logic                     eoi_seen = 1'b0;

    t_verdict   verdicts_due[$];
    logic [7:0] seg_bytes[$];
    int         errors = 0;
    int         bytes_sent = 0;
    bit         quiet_phase = 1'b0;
    int         out_hold = 0;

    // Directed segments. Every byte row is a request; cfg rows wait for idle.
    t_row directed_rows [32] = '{
        '{ROW_BYTE, '0, 21'h00, 1'b0, 1'b0, ST_VALID, 0, 0},
        '{ROW_BYTE, '0, 21'(FILL_BYTE), 1'b0, 1'b0, ST_VALID, 0, 0},
        '{ROW_BYTE, '0, 21'(STUFF_BYTE), 1'b0, 1'b0, ST_VALID, 0, 0},
        '{ROW_BYTE, '0, 21'(FILL_BYTE), 1'b0, 1'b0, ST_VALID, 0, 0},
        '{ROW_BYTE, '0, 21'(EOI_CODE), 1'b1, 1'b1, ST_VALID, 5, 0},
        // stuffing after a run of several fill bytes
        '{ROW_BYTE, '0, 21'(FILL_BYTE), 1'b0, 1'b0, ST_VALID, 0, 0},
        '{ROW_BYTE, '0, 21'(FILL_BYTE), 1'b0, 1'b0, ST_VALID, 0, 0},
        '{ROW_BYTE, '0, 21'(FILL_BYTE), 1'b0, 1'b0, ST_VALID, 0, 0},
        '{ROW_BYTE, '0, 21'(STUFF_BYTE), 1'b1, 1'b1, ST_INVALID, 4, 0},
        // EOI before the last byte; later bytes still counted
        '{ROW_BYTE, '0, 21'(FILL_BYTE), 1'b0, 1'b0, ST_VALID, 0, 0},
        '{ROW_BYTE, '0, 21'(EOI_CODE), 1'b0, 1'b0, ST_VALID, 0, 0},
        '{ROW_BYTE, '0, 21'h7e, 1'b1, 1'b1, ST_UNSUPPORTED, 3, 0},
        // restart marker with no interval set
        '{ROW_BYTE, '0, 21'(FILL_BYTE), 1'b0, 1'b0, ST_VALID, 0, 0},
        '{ROW_BYTE, '0, 21'(RST_FIRST), 1'b0, 1'b0, ST_VALID, 0, 0},
        '{ROW_BYTE, '0, 21'(FILL_BYTE), 1'b1, 1'b1, ST_INVALID, 3, 0},
        // too short
        '{ROW_BYTE, '0, 21'(FILL_BYTE), 1'b0, 1'b0, ST_VALID, 0, 0},
        '{ROW_BYTE, '0, 21'(EOI_CODE), 1'b1, 1'b1, ST_INVALID, 2, 0},
        // upper data bits beyond the interval width are dropped
        '{ROW_CFG, CFG_MCUS_PER_RESTART, 21'h1f0001, 1'b0, 1'b0, ST_VALID, 0, 0},
        '{ROW_CFG, CFG_TOTAL_MCUS, 21'd3, 1'b0, 1'b0, ST_VALID, 0, 0},
        '{ROW_BYTE, '0, 21'(FILL_BYTE), 1'b0, 1'b0, ST_VALID, 0, 0},
        '{ROW_BYTE, '0, 21'(RST_FIRST), 1'b0, 1'b0, ST_VALID, 0, 0},
        '{ROW_BYTE, '0, 21'(FILL_BYTE), 1'b0, 1'b0, ST_VALID, 0, 0},
        '{ROW_BYTE, '0, 21'(RST_FIRST + 8'd1), 1'b0, 1'b0, ST_VALID, 0, 0},
        '{ROW_BYTE, '0, 21'(FILL_BYTE), 1'b0, 1'b0, ST_VALID, 0, 0},
        '{ROW_BYTE, '0, 21'(EOI_CODE), 1'b1, 1'b1, ST_VALID, 6, 2},
        // out-of-order restart marker
        '{ROW_BYTE, '0, 21'(FILL_BYTE), 1'b0, 1'b0, ST_VALID, 0, 0},
        '{ROW_BYTE, '0, 21'(RST_FIRST + 8'd1), 1'b0, 1'b0, ST_VALID, 0, 0},
        '{ROW_BYTE, '0, 21'(EOI_CODE), 1'b1, 1'b1, ST_INVALID, 3, 0},
        // zero MCU count behaves as one
        '{ROW_CFG, CFG_TOTAL_MCUS, 21'd0, 1'b0, 1'b0, ST_VALID, 0, 0},
        '{ROW_BYTE, '0, 21'h00, 1'b0, 1'b0, ST_VALID, 0, 0},
        '{ROW_BYTE, '0, 21'(FILL_BYTE), 1'b0, 1'b0, ST_VALID, 0, 0},
        '{ROW_BYTE, '0, 21'(EOI_CODE), 1'b1, 1'b0, ST_VALID, 0, 0}
    };

    function automatic int idle_len();
        int r;
        if (quiet_phase) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Advances the tracker by one byte; returns 1 with the verdict on a final byte.
    function automatic bit segment_verdict(input logic [7:0] b, input logic fin,
                                           output t_verdict v);
        longint unsigned n, iv, t1;
        v = '0;
        if (byte_tally != '1) byte_tally++;
        if (err_flag == ST_VALID) begin
            if (in_run) begin
                if (b == FILL_BYTE) begin
                    if (run_len != FILL_RUN_MAX) run_len++;
                end else begin
                    if (b == STUFF_BYTE) begin
                        if (run_len != 2'd1) err_flag = ST_INVALID;
                    end else if (b >= RST_FIRST && b <= RST_LAST) begin
                        // expected marker tracks the low three bits of the tally
                        if (model_interval == '0 || b[2:0] != rst_tally[2:0])
                            err_flag = ST_INVALID;
                        else if (rst_tally != '1)
                            rst_tally++;
                    end else if (b == EOI_CODE && fin) begin
                        eoi_seen = 1'b1;
                    end else begin
                        err_flag = ST_UNSUPPORTED;
                    end
                    in_run = 1'b0;
                    run_len = 2'd0;
                end
            end else if (b == FILL_BYTE) begin
                in_run = 1'b1;
                run_len = 2'd1;
            end
        end
        if (!fin) return 1'b0;

        n = rst_tally;
        iv = model_interval;
        t1 = model_mcus;
        if (t1 != 0) t1--;
        if (err_flag != ST_VALID)
            v.status = err_flag;
        else if (in_run || !eoi_seen)
            v.status = ST_INVALID;
        else if (iv == 0 ? n != 0 : (n * iv > t1 || t1 >= (n + 1) * iv))
            v.status = ST_INVALID;
        else if (byte_tally <= MIN_LENGTH)
            v.status = ST_INVALID;
        else
            v.status = ST_VALID;
        v.seg_len = byte_tally;
        v.restarts = rst_tally;

        err_flag = ST_VALID;
        in_run = 1'b0;
        run_len = 2'd0;
        rst_tally = '0;
        byte_tally = '0;
        eoi_seen = 1'b0;
        return 1'b1;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        i_final_byte <= fin;
        // hold the request until the unit takes it
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_MCUS_PER_RESTART)
            model_interval = val[INTERVAL_BITS-1:0];
        else
            model_mcus = val[MCU_BITS-1:0];
    endtask

    task automatic add_body();
        int n;
        logic [7:0] b;
        n = $urandom_range(0, 3);
        repeat (n) begin
            b = ($urandom_range(0, 4) == 0) ? FILL_BYTE : 8'($urandom);
            seg_bytes.push_back(b);
            if (b == FILL_BYTE) seg_bytes.push_back(STUFF_BYTE);
        end
    endtask

    task automatic build_clean(input int restarts);
        int r;
        seg_bytes.delete();
        add_body();
        for (r = 0; r < restarts; r++) begin
            seg_bytes.push_back(FILL_BYTE);
            if ($urandom_range(0, 3) == 0) seg_bytes.push_back(FILL_BYTE);
            seg_bytes.push_back(RST_FIRST + 8'(r % 8));
            add_body();
        end
        seg_bytes.push_back(FILL_BYTE);
        seg_bytes.push_back(EOI_CODE);
    endtask

    task automatic play_segment();
        t_verdict v;
        logic fin;
        foreach (seg_bytes[i]) begin
            fin = (i == seg_bytes.size() - 1);
            send_byte(seg_bytes[i], fin);
            if (segment_verdict(seg_bytes[i], fin, v)) verdicts_due.push_back(v);
        end
    endtask

    // receiver back-pressure: bursts of stall, none in quiet phases
    always @(posedge i_clk) begin
        if (out_hold == 0 && $urandom_range(0, 3) == 0) out_hold = idle_len();
        if (out_hold > 0) begin
            out_hold = out_hold - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t: unexpected result: status %0d length %0d restarts %0d",
                         $time, o_status, o_segment_length, o_restarts_seen);
                errors++;
            end else begin
                want = verdicts_due.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, o_status);
                    errors++;
                end
                if (o_segment_length !== want.seg_len) begin
                    $display("%0t: segment length expected %0d, got %0d",
                             $time, want.seg_len, o_segment_length);
                    errors++;
                end
                if (o_restarts_seen !== want.restarts) begin
                    $display("%0t: restarts expected %0d, got %0d",
                             $time, want.restarts, o_restarts_seen);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_verdict                 v;
        t_row                     row;
        int                       phase;
        int                       segs;
        int                       target;
        int                       pos;
        logic [INTERVAL_BITS-1:0] span;
        logic [MCU_BITS-1:0]      mcus;
        longint unsigned          t1;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG) begin
                settle();
                write_reg(row.idx, row.arg);
            end else begin
                send_byte(row.arg[7:0], row.fin);
                if (segment_verdict(row.arg[7:0], row.fin, v)) begin
                    if (row.typed) begin
                        v.status = row.st;
                        v.seg_len = row.len;
                        v.restarts = row.rst;
                    end
                    verdicts_due.push_back(v);
                end
            end
        end

        phase = 0;
        while (bytes_sent < TOTAL_BYTES) begin
            quiet_phase = (phase % 4 == 3);
            case (phase)
                0: begin
                    span = '1;
                    mcus = '0;
                end
                1: begin
                    span = '0;
                    mcus = '1;
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0: span = '0;
                        1: span = INTERVAL_BITS'(1);
                        2: span = INTERVAL_BITS'($urandom_range(2, 40));
                        default: span = INTERVAL_BITS'($urandom);
                    endcase
                    if ($urandom_range(0, 3) == 0)
                        mcus = MCU_BITS'($urandom);
                    else if (span == '0)
                        mcus = MCU_BITS'($urandom_range(0, 64));
                    else
                        mcus = MCU_BITS'(span * $urandom_range(0, 9)
                                         + $urandom_range(1, span));
                end
            endcase
            // a full idle point between phases: all verdicts in before each write
            settle();
            write_reg(CFG_MCUS_PER_RESTART,
                      {(CFG_DATA_BITS - INTERVAL_BITS)'($urandom), span});
            settle();
            write_reg(CFG_TOTAL_MCUS, CFG_DATA_BITS'(mcus));

            t1 = mcus;
            if (t1 != 0) t1--;
            target = (span == '0) ? 0 : int'(t1 / span);
            if (target > 12) target = $urandom_range(0, 9);

            segs = $urandom_range(3, 7);
            while (segs > 0 && bytes_sent < TOTAL_BYTES) begin
                case ($urandom_range(0, 9))
                    7, 8: begin
                        build_clean(target);
                        pos = $urandom_range(0, seg_bytes.size() - 1);
                        case ($urandom_range(0, 3))
                            0: seg_bytes[pos] = 8'($urandom);
                            1: seg_bytes.delete(seg_bytes.size() - 1);
                            2: begin
                                seg_bytes.insert(pos, 8'($urandom));
                                seg_bytes.insert(pos, FILL_BYTE);
                            end
                            default: begin
                                seg_bytes.insert(pos, STUFF_BYTE);
                                seg_bytes.insert(pos, FILL_BYTE);
                                seg_bytes.insert(pos, FILL_BYTE);
                            end
                        endcase
                    end
                    9: begin
                        seg_bytes.delete();
                        repeat ($urandom_range(1, 12)) begin
                            case ($urandom_range(0, 3))
                                0: seg_bytes.push_back(FILL_BYTE);
                                1: seg_bytes.push_back(8'($urandom_range(RST_FIRST, EOI_CODE)));
                                default: seg_bytes.push_back(8'($urandom));
                            endcase
                        end
                    end
                    default: build_clean(target);
                endcase
                play_segment();
                segs--;
            end
            phase++;
        end

        settle();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
